### src/sst_pkg.sv
// shared types and constants for the integer set span tracker
// no dependencies; imported by every other file of the block
package sst_pkg;

	localparam int CAPACITY = 64;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CFG_W    = 7;
	localparam int LIM_W    = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam int VAL_W    = 32;
	localparam int GAP_W    = VAL_W + 1;

	localparam logic [CFG_W-1:0] MAX_COUNT_RST = CFG_W'(64);
	localparam logic [GAP_W-1:0] GAP_NONE      = {GAP_W{1'b1}};
	localparam logic [VAL_W-1:0] SIGN_FLIP     = {1'b1, {(VAL_W-1){1'b0}}};

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_FEW  = 2'd2
	} status_t;

	typedef enum logic {
		OP_ADD   = 1'b0,
		OP_CLEAR = 1'b1
	} opcode_t;

	typedef struct packed {
		logic load;
		logic occ;
		logic tail;
	} cell_ctl_t;

endpackage

### src/integer_set_span_tracker_unit.sv
// top level of the integer set span tracker: chain of sorted cells and span pipeline
// depends on sst_pkg and sst_cell
//
// usage
//   input channel in_valid/in_ready carries one word: opcode and a signed value.
//   opcode add inserts the value at its sorted place in a row of cells, unless the set
//   is full; the cells above that place shift in the same cycle; opcode clear empties the set.
//   output channel out_valid/out_ready returns one word per input word: status,
//   element_count, shortest_span and longest_span.
//   the user sets max_count via cfg_wr_en/cfg_wr_data only while idle; the block does not enforce this.
// pipeline
//   a result passes the cell update, the neighbour gaps and end points, then the
//   running minimum and the output register.
//   a new word is accepted only while stages 1 and 2 are empty, so only one word is
//   in those stages at a time; the running minimum gap closes the loop.
// reset and stall
//   arst_n empties the set, sets max_count to 64 and drops out_valid.
//   a held result sits in the output register; one further word may be accepted
//   and then waits in the last stage until the receiver takes the result.
module integer_set_span_tracker_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [sst_pkg::CFG_W-1:0] cfg_wr_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      opcode,
	input  logic signed [31:0]        value,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [1:0]                status,
	output logic [6:0]                element_count,
	output logic [31:0]               shortest_span,
	output logic [31:0]               longest_span
);
	import sst_pkg::*;

	logic [CFG_W-1:0] max_count_q;
	logic [CNT_W-1:0] count_q;
	logic [GAP_W-1:0] best_gap_q;

	logic             accept;
	logic             is_clear;
	logic             is_full;
	logic             do_insert;
	logic [LIM_W-1:0] limit;
	logic [VAL_W-1:0] key;

	logic [VAL_W-1:0] cell_val [CAPACITY];
	logic [CAPACITY-1:0] cell_gt;
	logic [CAPACITY-1:0] cell_ins;
	cell_ctl_t        cell_ctl [CAPACITY];

	logic [VAL_W-1:0] lo_sel;
	logic [VAL_W-1:0] hi_sel;

	// stage 1
	logic             v_s1;
	logic             clr_s1;
	logic             full_s1;
	logic [CNT_W-1:0] cnt_s1;
	logic [VAL_W-1:0] key_s1;
	logic [VAL_W-1:0] lo_s1;
	logic [VAL_W-1:0] hi_s1;
	logic             has_lo_s1;
	logic             has_hi_s1;
	logic [GAP_W-1:0] gap_lo;
	logic [GAP_W-1:0] gap_hi;
	logic [VAL_W-1:0] top_sel;

	// stage 2
	logic             v_s2;
	logic             clr_s2;
	logic             full_s2;
	logic [CNT_W-1:0] cnt_s2;
	logic [GAP_W-1:0] gap_lo_s2;
	logic [GAP_W-1:0] gap_hi_s2;
	logic [VAL_W-1:0] longest_s2;
	logic [GAP_W-1:0] gap_min;
	logic [GAP_W-1:0] best_next;
	logic             move;
	logic             few;

	// output register
	logic             out_valid_q;
	logic [1:0]       status_q;
	logic [6:0]       count_out_q;
	logic [31:0]      shortest_q;
	logic [31:0]      longest_q;

	assign in_ready  = ~v_s1 & ~v_s2;
	assign accept    = in_valid & in_ready;
	assign key       = VAL_W'(value) ^ SIGN_FLIP;
	assign is_clear  = (opcode == OP_CLEAR);
	assign limit     = (LIM_W'(max_count_q) < LIM_W'(CAPACITY)) ? LIM_W'(max_count_q)
	                                                            : LIM_W'(CAPACITY);
	assign is_full   = (LIM_W'(count_q) >= limit);
	assign do_insert = accept & ~is_clear & ~is_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_count_q <= MAX_COUNT_RST;
		end else if (cfg_wr_en) begin
			max_count_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			if (is_clear) begin
				count_q <= '0;
			end else if (!is_full) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	// row of cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign cell_ctl[i].load = do_insert;
		assign cell_ctl[i].occ  = (CNT_W'(i) < count_q);
		assign cell_ctl[i].tail = (CNT_W'(i) == count_q);
		if (i == 0) begin : g_head
			assign cell_ins[i] = cell_gt[i] | cell_ctl[i].tail;
			sst_cell u_cell (
				.clk      (clk),
				.ctl      (cell_ctl[i]),
				.key      (key),
				.prev_gt  (1'b0),
				.prev_val (key),
				.val      (cell_val[i]),
				.gt       (cell_gt[i])
			);
		end else begin : g_body
			assign cell_ins[i] = ~cell_gt[i-1] & (cell_gt[i] | cell_ctl[i].tail);
			sst_cell u_cell (
				.clk      (clk),
				.ctl      (cell_ctl[i]),
				.key      (key),
				.prev_gt  (cell_gt[i-1]),
				.prev_val (cell_val[i-1]),
				.val      (cell_val[i]),
				.gt       (cell_gt[i])
			);
		end
	end

	// neighbours of the insertion point
	always_comb begin
		lo_sel = '0;
		hi_sel = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (i > 0 && cell_ins[i]) begin
				lo_sel = lo_sel | cell_val[i-1];
			end
			if (cell_ins[i] && cell_gt[i]) begin
				hi_sel = hi_sel | cell_val[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			clr_s1    <= is_clear;
			full_s1   <= ~is_clear & is_full;
			cnt_s1    <= is_clear ? '0 : (is_full ? count_q : count_q + CNT_W'(1));
			key_s1    <= key;
			lo_s1     <= lo_sel;
			hi_s1     <= hi_sel;
			has_lo_s1 <= do_insert & ~cell_gt[0] & (count_q != '0);
			has_hi_s1 <= do_insert & (|cell_gt);
		end
	end

	// gaps to the neighbours and the largest held value
	assign gap_lo = has_lo_s1 ? {1'b0, key_s1 - lo_s1} : GAP_NONE;
	assign gap_hi = has_hi_s1 ? {1'b0, hi_s1 - key_s1} : GAP_NONE;

	always_comb begin
		top_sel = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (CNT_W'(i + 1) == cnt_s1) begin
				top_sel = top_sel | cell_val[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (v_s1) begin
			v_s2 <= 1'b1;
		end else if (move) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			clr_s2     <= clr_s1;
			full_s2    <= full_s1;
			cnt_s2     <= cnt_s1;
			gap_lo_s2  <= gap_lo;
			gap_hi_s2  <= gap_hi;
			longest_s2 <= top_sel - cell_val[0];
		end
	end

	// running minimum gap
	assign gap_min   = (gap_lo_s2 < gap_hi_s2) ? gap_lo_s2 : gap_hi_s2;
	assign best_next = clr_s2 ? GAP_NONE : ((gap_min < best_gap_q) ? gap_min : best_gap_q);
	assign move      = v_s2 & (~out_valid_q | out_ready);
	assign few       = (cnt_s2 < CNT_W'(2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_gap_q  <= GAP_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (move) begin
				best_gap_q  <= best_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			count_out_q <= 7'(cnt_s2);
			if (few) begin
				status_q   <= full_s2 ? ST_FULL : ST_FEW;
				shortest_q <= '0;
				longest_q  <= '0;
			end else begin
				status_q   <= full_s2 ? ST_FULL : ST_OK;
				shortest_q <= best_next[VAL_W-1:0];
				longest_q  <= longest_s2;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign element_count = count_out_q;
	assign shortest_span = shortest_q;
	assign longest_span  = longest_q;

endmodule

### src/sst_cell.sv
// one compare-and-shift cell of the sorted chain
// depends on sst_pkg
module sst_cell (
	input  logic                      clk,
	input  sst_pkg::cell_ctl_t        ctl,
	input  logic [sst_pkg::VAL_W-1:0] key,
	input  logic                      prev_gt,
	input  logic [sst_pkg::VAL_W-1:0] prev_val,
	output logic [sst_pkg::VAL_W-1:0] val,
	output logic                      gt
);
	import sst_pkg::*;

	logic [VAL_W-1:0] val_q;

	assign val = val_q;
	assign gt  = ctl.occ & (val_q > key);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			if (prev_gt) begin
				val_q <= prev_val;
			end else if (gt | ctl.tail) begin
				val_q <= key;
			end
		end
	end

endmodule

### src/sst_checker.sv
// port-level checks for the integer set span tracker
// depends on sst_pkg; bound to integer_set_span_tracker_unit below
module sst_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      cfg_wr_en,
	input logic [sst_pkg::CFG_W-1:0] cfg_wr_data,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      opcode,
	input logic signed [31:0]        value,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [1:0]                status,
	input logic [6:0]                element_count,
	input logic [31:0]               shortest_span,
	input logic [31:0]               longest_span
);
	import sst_pkg::*;

	// too few values means both spans are zero
	a_few_spans: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && element_count < 7'd2) |-> (shortest_span == '0 && longest_span == '0))
		else $error("spans not zero with fewer than two values");

	a_few_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_FEW) |-> (element_count < 7'd2))
		else $error("too-few status with two or more values");

	a_span_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (shortest_span <= longest_span))
		else $error("shortest span above longest span");

	// ok status needs between two and CAPACITY values
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_OK) |-> (element_count >= 7'd2 && element_count <= 7'(CAPACITY)))
		else $error("ok status with impossible count");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(element_count)))
		else $error("result word changed while stalled");

endmodule

bind integer_set_span_tracker_unit sst_checker u_sst_checker (.*);
